// ===== design/st_pkg.sv =====
// Package for the source tokenizer: token kinds, keyword tables, scan modes, input and output word types.
// No dependencies.
package st_pkg;

    // token kinds
    localparam logic [4:0] K_NUMBER = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_STRING = 5'd2;
    localparam logic [4:0] K_PLUS   = 5'd3;
    localparam logic [4:0] K_MINUS  = 5'd4;
    localparam logic [4:0] K_STAR   = 5'd5;
    localparam logic [4:0] K_SLASH  = 5'd6;
    localparam logic [4:0] K_ASSIGN = 5'd7;
    localparam logic [4:0] K_EQEQ   = 5'd8;
    localparam logic [4:0] K_NEQ    = 5'd9;
    localparam logic [4:0] K_LT     = 5'd10;
    localparam logic [4:0] K_GT     = 5'd11;
    localparam logic [4:0] K_LE     = 5'd12;
    localparam logic [4:0] K_GE     = 5'd13;
    localparam logic [4:0] K_LPAREN = 5'd14;
    localparam logic [4:0] K_RPAREN = 5'd15;
    localparam logic [4:0] K_LBRACE = 5'd16;
    localparam logic [4:0] K_RBRACE = 5'd17;
    localparam logic [4:0] K_SEMI   = 5'd18;
    localparam logic [4:0] K_COMMA  = 5'd19;
    localparam logic [4:0] K_KW0    = 5'd20;
    localparam logic [4:0] K_EOF    = 5'd29;
    localparam logic [4:0] K_ERROR  = 5'd30;

    localparam int KW_COUNT = 9;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h766172, 48'h6966, 48'h656C7365, 48'h7768696C65, 48'h66756E63,
        48'h72657475726E, 48'h7072696E74, 48'h74727565, 48'h66616C7365};
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd4,
        3'd6, 3'd5, 3'd4, 3'd5};

    // scan modes, one-hot
    typedef enum logic [11:0] {
        M_IDLE    = 12'b000000000001,
        M_SLASH   = 12'b000000000010,
        M_COMMENT = 12'b000000000100,
        M_INT     = 12'b000000001000,
        M_DOT     = 12'b000000010000,
        M_FRAC    = 12'b000000100000,
        M_IDENT   = 12'b000001000000,
        M_STRING  = 12'b000010000000,
        M_EQ      = 12'b000100000000,
        M_BANG    = 12'b001000000000,
        M_LT      = 12'b010000000000,
        M_GT      = 12'b100000000000
    } t_mode;

    // one output word
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [31:0] token_line;
        logic [47:0] number_mantissa;
        logic [5:0]  fraction_digits;
        logic        number_saturated;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_char;

endpackage

// ===== design/st_if.sv =====
// Valid/ready channel interface carrying one word.
// Depends on nothing; payload type is a parameter.
interface st_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/source_tokenizer_top.sv =====
// Source tokenizer: one source byte in per cycle while the queue has room, up to three tokens out.
// Depends on st_pkg and st_if.
//
// Accepts one byte per cycle. Each byte is decoded combinationally into 0..3 tokens that land
// in a six-entry output queue; a byte is taken whenever at least three entries are free, so
// input runs at one byte per cycle as long as the sink drains about one token per cycle.
// Tokens leave one per cycle from the queue while the sink is ready. No clearing pass after reset.
module source_tokenizer_top #(
    parameter int POSITION_BITS = 32,
    parameter int MANTISSA_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    st_if.sink   i_char,
    st_if.source o_token
);
    localparam int QD = 6;
    localparam int QW = 3;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

    st_pkg::t_mode r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos, r_line, n_line;
    logic [POSITION_BITS-1:0] r_lstart, n_lstart, r_llen, n_llen;
    logic [47:0] r_win, n_win;
    logic [MANTISSA_BITS-1:0] r_mant, n_mant;
    logic [5:0] r_frac, n_frac;
    logic r_sat, n_sat;

    // output queue
    st_pkg::t_token r_q [QD];
    logic [QW-1:0] r_rd, r_wr, r_cnt;
    st_pkg::t_token e_tok [3];
    logic [1:0] e_n;

    logic       acc;
    logic [7:0] c;
    logic       ends;
    assign c    = i_char.data.in_byte;
    assign ends = i_char.data.end_of_input | (c == 8'd0);
    assign i_char.ready = (r_cnt <= QW'(QD - 3));
    assign acc = i_char.valid & i_char.ready;

    function automatic logic is_dig(input logic [7:0] x);
        return x >= 8'h30 && x <= 8'h39;
    endfunction
    function automatic logic is_alp(input logic [7:0] x);
        return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A);
    endfunction

    // digit accumulation with saturation (mantissa*10 + d)
    logic [MANTISSA_BITS+3:0] mul10;
    logic dig_ovf;
    logic [MANTISSA_BITS-1:0] mant_dig;
    logic [MANTISSA_BITS-1:0] mant_src;
    logic sat_src;
    always_comb begin
        mul10 = {r_mant, 3'b000} + {3'b000, r_mant, 1'b0}
              + (MANTISSA_BITS+4)'(c - 8'h30);
        dig_ovf = |mul10[MANTISSA_BITS+3:MANTISSA_BITS];
        mant_dig = dig_ovf ? MANT_MAX : mul10[MANTISSA_BITS-1:0];
    end
    // fresh-start digit
    assign mant_src = MANTISSA_BITS'(c - 8'h30);
    assign sat_src  = 1'b0;

    // keyword match
    logic [4:0] id_kind;
    always_comb begin
        id_kind = st_pkg::K_IDENT;
        for (int k = st_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (r_llen == POSITION_BITS'(st_pkg::KW_LEN[k]) && r_win == st_pkg::KW_TEXT[k])
                id_kind = st_pkg::K_KW0 + 5'(k);
        end
    end

    function automatic st_pkg::t_token mk(input logic [4:0] k,
            input logic [POSITION_BITS-1:0] s, input logic [POSITION_BITS-1:0] l,
            input logic [POSITION_BITS-1:0] ln, input logic [47:0] m,
            input logic [5:0] f, input logic sa);
        st_pkg::t_token t;
        t.token_kind = k;
        t.token_start = 32'(s);
        t.token_length = 32'(l);
        t.token_line = 32'(ln);
        t.number_mantissa = m;
        t.fraction_digits = f;
        t.number_saturated = sa;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    logic [47:0] mant48;
    logic [4:0]  pk_pair, pk_single;
    logic        fall;
    logic [POSITION_BITS-1:0] one;
    assign one = POSITION_BITS'(1);
    // mantissa as carried on the word: low 48 bits
    assign mant48 = 48'(r_mant);

    // next-state and token generation
    always_comb begin
        logic [4:0] sk;
        logic [POSITION_BITS-1:0] ln_now;
        n_mode = r_mode; n_pos = r_pos; n_line = r_line;
        n_lstart = r_lstart; n_llen = r_llen; n_win = r_win;
        n_mant = r_mant; n_frac = r_frac; n_sat = r_sat;
        e_n = 2'd0;
        sk = st_pkg::K_ERROR;
        ln_now = r_line;
        for (int j = 0; j < 3; j++) e_tok[j] = '0;
        fall = 1'b1;
        pk_pair = st_pkg::K_GE; pk_single = st_pkg::K_GT;
        case (r_mode)
            st_pkg::M_EQ:   begin pk_pair = st_pkg::K_EQEQ; pk_single = st_pkg::K_ASSIGN; end
            st_pkg::M_BANG: begin pk_pair = st_pkg::K_NEQ;  pk_single = st_pkg::K_ERROR; end
            st_pkg::M_LT:   begin pk_pair = st_pkg::K_LE;   pk_single = st_pkg::K_LT; end
            default:        begin pk_pair = st_pkg::K_GE;   pk_single = st_pkg::K_GT; end
        endcase

        // pending token of the current mode
        case (r_mode)
            st_pkg::M_COMMENT: begin
                if (!ends) begin
                    if (c == 8'h0A) begin
                        n_line = r_line + one;
                        n_mode = st_pkg::M_IDLE;
                    end
                    fall = 1'b0;
                end
            end
            st_pkg::M_STRING: begin
                if (ends) begin
                    e_tok[0] = mk(st_pkg::K_STRING, r_lstart, r_llen, r_line, '0, '0, 1'b0);
                    e_n = 2'd1;
                end else if (c == 8'h22) begin
                    e_tok[0] = mk(st_pkg::K_STRING, r_lstart, r_llen, r_line, '0, '0, 1'b0);
                    e_n = 2'd1;
                    n_mode = st_pkg::M_IDLE;
                    fall = 1'b0;
                end else begin
                    n_llen = r_llen + one;
                    if (c == 8'h0A) n_line = r_line + one;
                    fall = 1'b0;
                end
            end
            st_pkg::M_IDENT: begin
                if (!ends && (is_alp(c) || is_dig(c) || c == 8'h5F)) begin
                    n_win = {r_win[39:0], c};
                    n_llen = r_llen + one;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(id_kind, r_lstart, r_llen, r_line, '0, '0, 1'b0);
                    e_n = 2'd1;
                end
            end
            st_pkg::M_INT: begin
                if (!ends && is_dig(c)) begin
                    n_mant = mant_dig; n_sat = r_sat | dig_ovf;
                    n_llen = r_llen + one;
                    fall = 1'b0;
                end else if (!ends && c == 8'h2E) begin
                    n_mode = st_pkg::M_DOT;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(st_pkg::K_NUMBER, r_lstart, r_llen, r_line, mant48,
                                  r_frac, r_sat);
                    e_n = 2'd1;
                end
            end
            st_pkg::M_DOT: begin
                if (!ends && is_dig(c)) begin
                    n_mant = mant_dig; n_sat = r_sat | dig_ovf;
                    n_frac = 6'd1;
                    n_llen = r_llen + POSITION_BITS'(2);
                    n_mode = st_pkg::M_FRAC;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(st_pkg::K_NUMBER, r_lstart, r_llen, r_line, mant48,
                                  r_frac, r_sat);
                    e_tok[1] = mk(st_pkg::K_ERROR, r_lstart + r_llen, one, r_line,
                                  '0, '0, 1'b0);
                    e_n = 2'd2;
                end
            end
            st_pkg::M_FRAC: begin
                if (!ends && is_dig(c)) begin
                    n_mant = mant_dig;
                    n_sat = r_sat | dig_ovf | (r_frac == 6'd63);
                    if (r_frac != 6'd63) n_frac = r_frac + 6'd1;
                    n_llen = r_llen + one;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(st_pkg::K_NUMBER, r_lstart, r_llen, r_line, mant48,
                                  r_frac, r_sat);
                    e_n = 2'd1;
                end
            end
            st_pkg::M_SLASH: begin
                if (!ends && c == 8'h2F) begin
                    n_mode = st_pkg::M_COMMENT;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(st_pkg::K_SLASH, r_lstart, one, r_line, '0, '0, 1'b0);
                    e_n = 2'd1;
                end
            end
            st_pkg::M_EQ, st_pkg::M_BANG, st_pkg::M_LT, st_pkg::M_GT: begin
                if (!ends && c == 8'h3D) begin
                    e_tok[0] = mk(pk_pair, r_lstart, POSITION_BITS'(2), r_line,
                                  '0, '0, 1'b0);
                    n_mode = st_pkg::M_IDLE;
                    fall = 1'b0;
                end else begin
                    e_tok[0] = mk(pk_single, r_lstart, one, r_line, '0, '0, 1'b0);
                end
                e_n = 2'd1;
            end
            default: ;
        endcase

        if (ends) begin
            // flush: eof, then restart
            e_tok[e_n] = mk(st_pkg::K_EOF, r_pos, '0, n_line, '0, '0, 1'b0);
            e_n = e_n + 2'd1;
            n_mode = st_pkg::M_IDLE; n_pos = '0; n_line = one;
            n_lstart = '0; n_llen = '0; n_win = '0;
            n_mant = '0; n_frac = '0; n_sat = 1'b0;
        end else begin
            if (fall) begin
                n_mode = st_pkg::M_IDLE;
                ln_now = n_line;
                case (c)
                    8'h20, 8'h09, 8'h0D: sk = st_pkg::K_EOF;
                    8'h0A: begin n_line = n_line + one; sk = st_pkg::K_EOF; end
                    8'h22: begin
                        n_mode = st_pkg::M_STRING;
                        n_lstart = r_pos + one; n_llen = '0; sk = st_pkg::K_EOF;
                    end
                    8'h2F: begin n_mode = st_pkg::M_SLASH; sk = st_pkg::K_EOF; end
                    8'h3D: begin n_mode = st_pkg::M_EQ;    sk = st_pkg::K_EOF; end
                    8'h21: begin n_mode = st_pkg::M_BANG;  sk = st_pkg::K_EOF; end
                    8'h3C: begin n_mode = st_pkg::M_LT;    sk = st_pkg::K_EOF; end
                    8'h3E: begin n_mode = st_pkg::M_GT;    sk = st_pkg::K_EOF; end
                    8'h2B: sk = st_pkg::K_PLUS;
                    8'h2D: sk = st_pkg::K_MINUS;
                    8'h2A: sk = st_pkg::K_STAR;
                    8'h28: sk = st_pkg::K_LPAREN;
                    8'h29: sk = st_pkg::K_RPAREN;
                    8'h7B: sk = st_pkg::K_LBRACE;
                    8'h7D: sk = st_pkg::K_RBRACE;
                    8'h3B: sk = st_pkg::K_SEMI;
                    8'h2C: sk = st_pkg::K_COMMA;
                    default: sk = st_pkg::K_ERROR;
                endcase
                if (is_dig(c)) begin
                    n_mode = st_pkg::M_INT; sk = st_pkg::K_EOF;
                    n_mant = mant_src; n_frac = '0; n_sat = sat_src;
                end else if (is_alp(c) || c == 8'h5F) begin
                    n_mode = st_pkg::M_IDENT; sk = st_pkg::K_EOF;
                    n_win = {40'd0, c};
                end
                // two-char lead and token-openers record start
                if (n_mode != st_pkg::M_IDLE && n_mode != st_pkg::M_STRING) begin
                    n_lstart = r_pos; n_llen = one;
                end
                if (sk != st_pkg::K_EOF) begin
                    e_tok[e_n] = mk(sk, r_pos, one, ln_now, '0, '0, 1'b0);
                    e_n = e_n + 2'd1;
                end
            end
            n_pos = r_pos + one;
        end
        if (e_n != 2'd0) e_tok[e_n - 2'd1].last_of_run = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= st_pkg::M_IDLE;
            r_pos <= '0; r_line <= one; r_lstart <= '0; r_llen <= '0;
            r_win <= '0; r_mant <= '0; r_frac <= '0; r_sat <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_pos <= n_pos; r_line <= n_line; r_lstart <= n_lstart; r_llen <= n_llen;
            r_win <= n_win; r_mant <= n_mant; r_frac <= n_frac; r_sat <= n_sat;
        end
    end

    // output queue
    logic pop;
    logic [1:0] push_n;
    assign pop = o_token.valid & o_token.ready;
    assign push_n = acc ? e_n : 2'd0;

    function automatic logic [QW-1:0] qadd(input logic [QW-1:0] a, input logic [1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {{(QW-1){1'b0}}, b};
        if (s >= (QW+1)'(QD)) s = s - (QW+1)'(QD);
        return s[QW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (32'(j) < 32'(push_n)) r_q[qadd(r_wr, 2'(j))] <= e_tok[j];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr <= qadd(r_wr, push_n);
            if (pop) r_rd <= qadd(r_rd, 2'd1);
            r_cnt <= r_cnt + QW'(push_n) - QW'(pop);
        end
    end
    assign o_token.valid = (r_cnt != '0);
    assign o_token.data  = r_q[r_rd];

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QW'(QD)) else $error("queue over depth");
    a_no_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > QW'(QD - 3)) |-> !i_char.ready) else $error("ready while full");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ends) |=> (r_pos == '0 && r_mode == st_pkg::M_IDLE))
        else $error("no restart after end");
    a_line_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 || $past(r_line) != '0) else $error("line count zero");
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for source_tokenizer_top: directed and random source text.
// Depends on st_pkg, st_if and the tokenizer RTL.
module tb_top;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    st_if #(.T(st_pkg::t_char))  char_ch ();
    st_if #(.T(st_pkg::t_token)) tok_ch ();

    source_tokenizer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch.sink),
        .o_token (tok_ch.source)
    );

    always #10 i_clk = ~i_clk;

    localparam logic [47:0] MANT_TOP = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  CH_LF    = 8'h0A;

    // lexer state as predicted
    st_pkg::t_mode lex_mode;
    logic [31:0] src_pos, src_line, lex_start, lex_len;
    logic [47:0] kw_window, mant_acc;
    logic [5:0]  frac_cnt;
    logic        sat_flag;

    st_pkg::t_token token_q[$];
    int     err_cnt = 0;
    int     byte_cnt = 0;
    int     token_cnt = 0;
    int     stream_cnt = 0;
    bit     no_gaps = 0;

    // ---------------- predictor ----------------
    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic lex_clear();
        lex_mode = st_pkg::M_IDLE; src_pos = 0; src_line = 1; lex_start = 0; lex_len = 0;
        kw_window = 0; mant_acc = 0; frac_cnt = 0; sat_flag = 0;
    endtask

    task automatic push_token(logic [4:0] kind, logic [31:0] start, logic [31:0] len,
                              logic [47:0] mant, logic [5:0] frac, logic sat);
        st_pkg::t_token t;
        t.token_kind = kind; t.token_start = start; t.token_length = len;
        t.token_line = src_line; t.number_mantissa = mant; t.fraction_digits = frac;
        t.number_saturated = sat; t.last_of_run = 1'b0;
        token_q.push_back(t);
    endtask

    task automatic acc_digit(logic [7:0] c);
        logic [47:0] d;
        d = 48'(c - "0");
        if (mant_acc > (MANT_TOP - d) / 10) begin
            mant_acc = MANT_TOP;
            sat_flag = 1'b1;
        end else begin
            mant_acc = mant_acc * 10 + d;
        end
    endtask

    task automatic push_ident();
        logic [4:0] kind;
        kind = st_pkg::K_IDENT;
        for (int i = st_pkg::KW_COUNT - 1; i >= 0; i--)
            if (lex_len == 32'(st_pkg::KW_LEN[i]) && kw_window == st_pkg::KW_TEXT[i])
                kind = st_pkg::K_KW0 + 5'(i);
        push_token(kind, lex_start, lex_len, 0, 0, 0);
    endtask

    task automatic open_lexeme(st_pkg::t_mode m, logic [31:0] at);
        lex_mode = m; lex_start = at; lex_len = 1;
    endtask

    // byte seen with nothing pending
    task automatic scan_fresh(logic [7:0] c, logic [31:0] at);
        logic [4:0] kind;
        kind = st_pkg::K_ERROR;
        lex_mode = st_pkg::M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0D) return;
        if (c == CH_LF) begin src_line++; return; end
        if (is_num(c)) begin
            open_lexeme(st_pkg::M_INT, at);
            mant_acc = 0; frac_cnt = 0; sat_flag = 0;
            acc_digit(c);
            return;
        end
        if (is_letter(c) || c == "_") begin
            open_lexeme(st_pkg::M_IDENT, at);
            kw_window = 48'(c);
            return;
        end
        if (c == "\"") begin
            lex_mode = st_pkg::M_STRING; lex_start = at + 1; lex_len = 0;
            return;
        end
        case (c)
            "/": begin open_lexeme(st_pkg::M_SLASH, at); return; end
            "=": begin open_lexeme(st_pkg::M_EQ, at); return; end
            "!": begin open_lexeme(st_pkg::M_BANG, at); return; end
            "<": begin open_lexeme(st_pkg::M_LT, at); return; end
            ">": begin open_lexeme(st_pkg::M_GT, at); return; end
            "+": kind = st_pkg::K_PLUS;
            "-": kind = st_pkg::K_MINUS;
            "*": kind = st_pkg::K_STAR;
            "(": kind = st_pkg::K_LPAREN;
            ")": kind = st_pkg::K_RPAREN;
            "{": kind = st_pkg::K_LBRACE;
            "}": kind = st_pkg::K_RBRACE;
            ";": kind = st_pkg::K_SEMI;
            ",": kind = st_pkg::K_COMMA;
            default: ;
        endcase
        push_token(kind, at, 1, 0, 0, 0);
    endtask

    // advance the lexer by one accepted word
    task automatic lex_byte(logic [7:0] c, logic eoi);
        bit          fin, rescan;
        logic [31:0] at;
        int          n0;
        logic [4:0]  pair_k, single_k;
        fin = eoi || c == 8'h00;
        at = src_pos;
        rescan = 1;
        n0 = token_q.size();
        case (lex_mode)
            st_pkg::M_COMMENT: if (!fin) begin
                if (c == CH_LF) begin src_line++; lex_mode = st_pkg::M_IDLE; end
                rescan = 0;
            end
            st_pkg::M_STRING: if (fin) begin
                push_token(st_pkg::K_STRING, lex_start, lex_len, 0, 0, 0);
            end else if (c == "\"") begin
                push_token(st_pkg::K_STRING, lex_start, lex_len, 0, 0, 0);
                lex_mode = st_pkg::M_IDLE; rescan = 0;
            end else begin
                lex_len++;
                if (c == CH_LF) src_line++;
                rescan = 0;
            end
            st_pkg::M_IDENT: if (!fin && (is_letter(c) || is_num(c) || c == "_")) begin
                kw_window = {kw_window[39:0], c};
                lex_len++; rescan = 0;
            end else push_ident();
            st_pkg::M_INT: if (!fin && is_num(c)) begin
                acc_digit(c); lex_len++; rescan = 0;
            end else if (!fin && c == ".") begin
                lex_mode = st_pkg::M_DOT; rescan = 0;
            end else push_token(st_pkg::K_NUMBER, lex_start, lex_len, mant_acc, frac_cnt,
                                sat_flag);
            st_pkg::M_DOT: if (!fin && is_num(c)) begin
                acc_digit(c); frac_cnt = 1; lex_len += 2; lex_mode = st_pkg::M_FRAC;
                rescan = 0;
            end else begin
                // point with no digit after it: number, then an error for the point
                push_token(st_pkg::K_NUMBER, lex_start, lex_len, mant_acc, frac_cnt, sat_flag);
                push_token(st_pkg::K_ERROR, lex_start + lex_len, 1, 0, 0, 0);
            end
            st_pkg::M_FRAC: if (!fin && is_num(c)) begin
                acc_digit(c);
                if (frac_cnt == 6'd63) sat_flag = 1'b1;
                else frac_cnt++;
                lex_len++; rescan = 0;
            end else push_token(st_pkg::K_NUMBER, lex_start, lex_len, mant_acc, frac_cnt,
                                sat_flag);
            st_pkg::M_SLASH: if (!fin && c == "/") begin
                lex_mode = st_pkg::M_COMMENT; rescan = 0;
            end else push_token(st_pkg::K_SLASH, lex_start, 1, 0, 0, 0);
            st_pkg::M_EQ, st_pkg::M_BANG, st_pkg::M_LT, st_pkg::M_GT: begin
                case (lex_mode)
                    st_pkg::M_EQ: begin
                        pair_k = st_pkg::K_EQEQ; single_k = st_pkg::K_ASSIGN;
                    end
                    st_pkg::M_BANG: begin
                        pair_k = st_pkg::K_NEQ;  single_k = st_pkg::K_ERROR;
                    end
                    st_pkg::M_LT: begin
                        pair_k = st_pkg::K_LE;   single_k = st_pkg::K_LT;
                    end
                    default: begin
                        pair_k = st_pkg::K_GE;   single_k = st_pkg::K_GT;
                    end
                endcase
                if (!fin && c == "=") begin
                    push_token(pair_k, lex_start, 2, 0, 0, 0);
                    lex_mode = st_pkg::M_IDLE; rescan = 0;
                end else push_token(single_k, lex_start, 1, 0, 0, 0);
            end
            default: ;
        endcase
        if (fin) begin
            push_token(st_pkg::K_EOF, at, 0, 0, 0, 0);
            lex_clear();
            stream_cnt++;
        end else begin
            if (rescan) scan_fresh(c, at);
            src_pos = at + 1;
        end
        if (token_q.size() > n0) token_q[token_q.size() - 1].last_of_run = 1'b1;
    endtask

    // ---------------- drivers ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(logic [7:0] c, logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.data <= '{in_byte: c, end_of_input: eoi};
        do @(posedge i_clk); while (!char_ch.ready);
        lex_byte(c, eoi);
        byte_cnt++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    // drop valid at the accepting edge, then wait for every expected token
    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        do @(posedge i_clk); while (token_q.size() != 0);
    endtask

    // sink readiness: mostly short stalls, a few long ones, and quiet stretches
    int stall_left = 0;
    int calm_left = 0;
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            tok_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            tok_ch.ready <= 1'b0;
        end else if (r < 3) begin
            stall_left = $urandom_range(5, 30);
            tok_ch.ready <= 1'b0;
        end else if (r < 6) begin
            calm_left = $urandom_range(20, 80);
            tok_ch.ready <= 1'b1;
        end else begin
            tok_ch.ready <= (r >= 30);
        end
    end

    // ---------------- checker ----------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch token %0d %s: got %0h want %0h", token_cnt, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        st_pkg::t_token got, want;
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            got = tok_ch.data;
            if (token_q.size() == 0) begin
                report("unexpected token", 64'(got.token_kind), 64'd0);
            end else begin
                want = token_q.pop_front();
                if (got.token_kind !== want.token_kind)
                    report("kind", 64'(got.token_kind), 64'(want.token_kind));
                if (got.token_start !== want.token_start)
                    report("start", 64'(got.token_start), 64'(want.token_start));
                if (got.token_length !== want.token_length)
                    report("length", 64'(got.token_length), 64'(want.token_length));
                if (got.token_line !== want.token_line)
                    report("line", 64'(got.token_line), 64'(want.token_line));
                if (got.number_mantissa !== want.number_mantissa)
                    report("mantissa", 64'(got.number_mantissa), 64'(want.number_mantissa));
                if (got.fraction_digits !== want.fraction_digits)
                    report("fraction", 64'(got.fraction_digits), 64'(want.fraction_digits));
                if (got.number_saturated !== want.number_saturated)
                    report("saturated", 64'(got.number_saturated),
                           64'(want.number_saturated));
                if (got.last_of_run !== want.last_of_run)
                    report("last", 64'(got.last_of_run), 64'(want.last_of_run));
            end
            token_cnt++;
        end
    end

    // ---------------- tests ----------------
    task automatic test_operators();
        send_text("<=>=!=== = < > ! !x/ + - * ( ) { } ; ,");
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_corner_text();
        // dangling point, unknown bytes, comment running into end of text
        send_text("1.a 2.5");
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_text("_v9//c");
        send_byte(8'h5A, 1'b1);
        // unterminated string ends at end of text
        send_text("x\"a\nb");
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_saturation();
        send_text("281474976710655 281474976710656 ");
        send_text("99999999999999999999.5\n0.");
        repeat (66) send_byte("7", 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic send_lexeme();
        string kws[9] = '{"var", "if", "else", "while", "func", "return", "print",
                          "true", "false"};
        string ops = "+-*/=!<>(){};,.";
        string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        int    n;
        case ($urandom_range(0, 9))
            0, 1: send_text(kws[$urandom_range(0, 8)]);
            2: begin
                send_byte(alnum[$urandom_range(0, 52)], 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) send_byte(alnum[$urandom_range(0, 62)], 1'b0);
            end
            3, 4: begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_byte(".", 1'b0);
                    n = $urandom_range(0, 4);
                    repeat (n) send_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
                end
            end
            5: begin
                send_byte("\"", 1'b0);
                n = $urandom_range(0, 5);
                repeat (n) send_byte($urandom_range(0, 2) == 0 ? CH_LF :
                                     alnum[$urandom_range(0, 62)], 1'b0);
                send_byte("\"", 1'b0);
            end
            6: begin
                send_byte(ops[$urandom_range(0, 14)], 1'b0);
                if ($urandom_range(0, 2) == 0) send_byte("=", 1'b0);
            end
            7: send_text("// note\n");
            8: send_byte(8'($urandom_range(1, 255)), 1'b0);
            default: send_byte($urandom_range(0, 1) ? CH_LF : 8'h09, 1'b0);
        endcase
        if ($urandom_range(0, 2) != 0) send_byte(" ", 1'b0);
    endtask

    task automatic test_random(int budget);
        int stop_at, paused;
        stop_at = byte_cnt + budget;
        paused = 0;
        while (byte_cnt < stop_at) begin
            send_lexeme();
            if ($urandom_range(0, 24) == 0)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) ? 1'b1 : 1'b0);
            if ($urandom_range(0, 30) == 0) no_gaps = !no_gaps;
            if (!paused && byte_cnt > stop_at - budget / 2) begin
                wait_drained();
                paused = 1;
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        no_gaps = 0;
    endtask

    initial begin
        char_ch.valid = 1'b0;
        char_ch.data = '0;
        tok_ch.ready = 1'b0;
        lex_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operators();
        test_corner_text();
        test_saturation();
        test_random(180);
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d source bytes in %0d streams, %0d tokens checked",
                 byte_cnt, stream_cnt, token_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d tokens outstanding", token_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
design/st_pkg.sv
design/st_if.sv
design/source_tokenizer_top.sv
tb/tb_top.sv
